[hdl/assert_macros.svh]
// assertion macros used by the rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, held off while reset is applied
`define TWRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define TWRC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/twrc_pkg.sv]
// types, constants and helper functions for the tcp window rewrite checksum block
`timescale 1ns / 1ps
`default_nettype none

package twrc_pkg;

	localparam int POS_W = 16;
	localparam int CNT_W = 32;
	localparam int IHL_W = 6;
	localparam int CFG_IDX_W = 1;

	localparam logic [POS_W-1:0] MAX_PACKET_BYTES = 16'hFFFF;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam int TCP_HDR_BYTES = 20;
	localparam int IP_MIN_BYTES = 20;
	localparam int ACK_BIT = 4;

	// tcp header byte offsets
	localparam logic [POS_W-1:0] OFF_SPORT_HI = 16'd0;
	localparam logic [POS_W-1:0] OFF_SPORT_LO = 16'd1;
	localparam logic [POS_W-1:0] OFF_FLAGS = 16'd13;
	localparam logic [POS_W-1:0] OFF_WIN_HI = 16'd14;
	localparam logic [POS_W-1:0] OFF_WIN_LO = 16'd15;
	localparam logic [POS_W-1:0] OFF_CSUM_HI = 16'd16;
	localparam logic [POS_W-1:0] OFF_CSUM_LO = 16'd17;

	// ip header byte positions
	localparam logic [POS_W-1:0] POS_VER_IHL = 16'd0;
	localparam logic [POS_W-1:0] POS_LEN_HI = 16'd2;
	localparam logic [POS_W-1:0] POS_LEN_LO = 16'd3;
	localparam logic [POS_W-1:0] POS_PROTO = 16'd9;
	localparam logic [POS_W-1:0] POS_ADDR_FIRST = 16'd12;
	localparam logic [POS_W-1:0] POS_ADDR_END = 16'd20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LISTEN_PORT   = 1'd0,
		REG_TARGET_WINDOW = 1'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OUT_PASSED    = 2'd0,
		OUT_MODIFIED  = 2'd1,
		OUT_NOT_TCP   = 2'd2,
		OUT_TOO_SHORT = 2'd3
	} outcome_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c, input logic en);
		logic [CNT_W-1:0] r;
		r = c;
		if (en && c != CNT_MAX) begin
			r = c + {{(CNT_W-1){1'b0}}, 1'b1};
		end
		return r;
	endfunction

	// places a byte in the high or low half of a big-endian word
	function automatic logic [15:0] word_part(input logic odd, input logic [7:0] v);
		return odd ? {8'h00, v} : {v, 8'h00};
	endfunction

endpackage

`default_nettype wire

[hdl/tcp_window_rewrite_checksum.sv]
// One IPv4 packet enters as a stream of bytes, one transaction per byte, last_byte set on
// the final one. Each byte is taken into an input register and folded into a running
// ones'-complement sum as it leaves that register, so the block takes one byte every clock cycle;
// the only stall comes when a packet's last byte finds the result register still held by
// an untaken result. One result per packet is registered after its last byte leaves the
// input register: the outcome, the TCP checksum with the window set to target_window,
// and four saturating statistics counters. listen_port and target_window are written
// through the cfg channel, which is always ready, and should only change between packets.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tcp_window_rewrite_checksum import twrc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data,

	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 last_byte,

	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [1:0]                outcome,
	output logic [15:0]               new_checksum,
	output logic [CNT_W-1:0]          packet_count,
	output logic [CNT_W-1:0]          modified_count,
	output logic [CNT_W-1:0]          error_count,
	output logic [CNT_W-1:0]          non_tcp_count
);

	// configuration
	logic [15:0] listen_port_q;
	logic [15:0] target_window_q;

	// input register
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;

	// per-packet state
	logic [POS_W-1:0] pos_q;
	logic [IHL_W-1:0] ihl_q;
	logic [15:0]      tl_q;
	logic [7:0]       proto_q;
	logic [15:0]      sport_q;
	logic [7:0]       flags_q;
	logic [7:0]       early0_q;
	logic [7:0]       early1_q;
	logic [15:0]      sum_q;
	logic [16:0]      pseudo_q;

	// result
	logic             out_valid_q;
	outcome_t         outcome_q;
	logic [15:0]      chk_q;
	logic [CNT_W-1:0] pkt_cnt_q;
	logic [CNT_W-1:0] mod_cnt_q;
	logic [CNT_W-1:0] err_cnt_q;
	logic [CNT_W-1:0] ntcp_cnt_q;

	logic             out_free;
	logic             go;
	logic             finish;
	logic             accept;
	logic             take;
	logic [POS_W-1:0] len;
	logic [IHL_W-1:0] ihl_now;
	logic [15:0]      tl_now;
	logic [POS_W-1:0] ihl_ext;
	logic             at_tcp;
	logic [POS_W-1:0] off;
	logic [7:0]       proto_now;
	logic [15:0]      sport_now;
	logic [7:0]       flags_now;
	logic [7:0]       sum_byte;
	logic             in_main;
	logic             in_addr;
	logic             at_len_lo;
	logic [15:0]      tl3;
	logic [3:0]       early_in;
	logic [15:0]      word01;
	logic [15:0]      word23;
	logic [15:0]      term_a;
	logic [15:0]      term_b;
	logic [17:0]      sum_raw;
	logic [16:0]      sum_f1;
	logic [15:0]      sum_next;
	logic [18:0]      chk_raw;
	logic [16:0]      chk_f1;
	logic [15:0]      chk_f2;
	logic [15:0]      tcp_len;
	outcome_t         outcome_d;
	logic             inc_pkt;
	logic             inc_mod;
	logic             inc_err;
	logic             inc_ntcp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listen_port_q   <= 16'd80;
			target_window_q <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LISTEN_PORT:   listen_port_q   <= cfg_data;
				REG_TARGET_WINDOW: target_window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: a last byte waits in the input register until the result register is free
	assign out_free = !out_valid_q || !out_stall;
	assign go       = valid_s1 && (!last_s1 || out_free);
	assign finish   = go && last_s1;
	assign in_stall = valid_s1 && !go;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// byte decode
	assign take      = pos_q != MAX_PACKET_BYTES;
	assign len       = take ? pos_q + 16'd1 : pos_q;
	assign ihl_now   = (take && pos_q == POS_VER_IHL) ? {data_s1[3:0], 2'b00} : ihl_q;
	assign ihl_ext   = {{(POS_W-IHL_W){1'b0}}, ihl_now};
	assign at_tcp    = take && pos_q >= ihl_ext;
	assign off       = pos_q - ihl_ext;
	assign at_len_lo = take && pos_q == POS_LEN_LO;

	always_comb begin
		tl_now = tl_q;
		if (take && pos_q == POS_LEN_HI) begin
			tl_now = {data_s1, 8'h00};
		end else if (at_len_lo) begin
			tl_now = {tl_q[15:8], data_s1};
		end
	end

	assign proto_now = (take && pos_q == POS_PROTO) ? data_s1 : proto_q;

	always_comb begin
		sport_now = sport_q;
		flags_now = flags_q;
		if (at_tcp) begin
			if (off == OFF_SPORT_HI) begin
				sport_now = {data_s1, sport_q[7:0]};
			end else if (off == OFF_SPORT_LO) begin
				sport_now = {sport_q[15:8], data_s1};
			end else if (off == OFF_FLAGS) begin
				flags_now = data_s1;
			end
		end
	end

	// window counts as the target value, checksum field as zero
	always_comb begin
		sum_byte = data_s1;
		if (off == OFF_WIN_HI) begin
			sum_byte = target_window_q[15:8];
		end else if (off == OFF_WIN_LO) begin
			sum_byte = target_window_q[7:0];
		end else if (off == OFF_CSUM_HI || off == OFF_CSUM_LO) begin
			sum_byte = 8'h00;
		end
	end

	assign in_main = at_tcp && pos_q >= 16'd4 && pos_q < tl_q;
	assign in_addr = take && pos_q >= POS_ADDR_FIRST && pos_q < POS_ADDR_END;

	// the first four bytes are summed once the total length is known
	assign tl3 = {tl_q[15:8], data_s1};
	always_comb begin
		for (int q = 0; q < 4; q++) begin
			early_in[q] = {{(POS_W-IHL_W){1'b0}}, ihl_q} <= POS_W'(q) && POS_W'(q) < tl3;
		end
	end
	assign word01 = {early_in[0] ? early0_q : 8'h00, early_in[1] ? early1_q : 8'h00};
	assign word23 = {early_in[2] ? tl_q[15:8] : 8'h00, early_in[3] ? data_s1 : 8'h00};

	assign term_a = at_len_lo ? word01 : (in_addr ? word_part(pos_q[0], data_s1) : 16'h0000);
	assign term_b = at_len_lo ? word23 : (in_main ? word_part(pos_q[0], sum_byte) : 16'h0000);

	assign sum_raw  = {2'b00, sum_q} + {2'b00, term_a} + {2'b00, term_b};
	assign sum_f1   = {1'b0, sum_raw[15:0]} + {15'd0, sum_raw[17:16]};
	assign sum_next = sum_f1[15:0] + {15'd0, sum_f1[16]};

	// protocol and tcp length of the pseudo-header, settled long before any tcp last byte
	assign tcp_len = (tl_q > {10'd0, ihl_q}) ? tl_q - {10'd0, ihl_q} : 16'd0;

	always_ff @(posedge clk) begin
		pseudo_q <= {1'b0, tcp_len} + {9'd0, PROTO_TCP};
	end

	assign chk_raw = {3'b000, sum_q} + {3'b000, term_a} + {3'b000, term_b}
		+ {2'b00, pseudo_q};
	assign chk_f1  = {1'b0, chk_raw[15:0]} + {14'd0, chk_raw[18:16]};
	assign chk_f2  = chk_f1[15:0] + {15'd0, chk_f1[16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			ihl_q    <= '0;
			tl_q     <= '0;
			proto_q  <= '0;
			sport_q  <= '0;
			flags_q  <= '0;
			early0_q <= '0;
			early1_q <= '0;
			sum_q    <= '0;
		end else if (finish) begin
			pos_q    <= '0;
			ihl_q    <= '0;
			tl_q     <= '0;
			proto_q  <= '0;
			sport_q  <= '0;
			flags_q  <= '0;
			early0_q <= '0;
			early1_q <= '0;
			sum_q    <= '0;
		end else if (go && take) begin
			pos_q   <= len;
			ihl_q   <= ihl_now;
			tl_q    <= tl_now;
			proto_q <= proto_now;
			sport_q <= sport_now;
			flags_q <= flags_now;
			sum_q   <= sum_next;
			if (pos_q == 16'd0) begin
				early0_q <= data_s1;
			end
			if (pos_q == 16'd1) begin
				early1_q <= data_s1;
			end
		end
	end

	// end of packet decision
	always_comb begin
		outcome_d = OUT_PASSED;
		inc_pkt   = 1'b0;
		inc_mod   = 1'b0;
		inc_err   = 1'b0;
		inc_ntcp  = 1'b0;
		if (len < POS_W'(IP_MIN_BYTES)) begin
			outcome_d = OUT_TOO_SHORT;
			inc_err   = 1'b1;
		end else begin
			inc_pkt = 1'b1;
			if (proto_now != PROTO_TCP) begin
				outcome_d = OUT_NOT_TCP;
				inc_ntcp  = 1'b1;
			end else if ({1'b0, len} < {1'b0, ihl_ext} + 17'(TCP_HDR_BYTES)) begin
				outcome_d = OUT_TOO_SHORT;
				inc_err   = 1'b1;
			end else if (sport_now == listen_port_q && flags_now[ACK_BIT]) begin
				outcome_d = OUT_MODIFIED;
				inc_mod   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pkt_cnt_q   <= '0;
			mod_cnt_q   <= '0;
			err_cnt_q   <= '0;
			ntcp_cnt_q  <= '0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
				pkt_cnt_q   <= sat_inc(pkt_cnt_q, inc_pkt);
				mod_cnt_q   <= sat_inc(mod_cnt_q, inc_mod);
				err_cnt_q   <= sat_inc(err_cnt_q, inc_err);
				ntcp_cnt_q  <= sat_inc(ntcp_cnt_q, inc_ntcp);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			outcome_q <= outcome_d;
			chk_q     <= (outcome_d == OUT_MODIFIED) ? ~chk_f2 : 16'h0000;
		end
	end

	// counters only move when a result is loaded, so they sit on the ports directly
	assign out_valid      = out_valid_q;
	assign outcome        = outcome_q;
	assign new_checksum   = chk_q;
	assign packet_count   = pkt_cnt_q;
	assign modified_count = mod_cnt_q;
	assign error_count    = err_cnt_q;
	assign non_tcp_count  = ntcp_cnt_q;

	`TWRC_ASSERT(a_stall_only_on_last, in_stall |-> (valid_s1 && last_s1 && !out_free),
		"input stalled without a waiting last byte")
	`TWRC_ASSERT(a_state_clear_after_last, finish |=> (pos_q == '0 && sum_q == '0),
		"packet state not cleared after last byte")
	`TWRC_ASSERT(a_chk_only_modified,
		(out_valid_q && outcome_q != OUT_MODIFIED) |-> new_checksum == 16'h0000,
		"checksum given on an unmodified packet")
	`TWRC_ASSERT(a_err_cnt_monotonic, 1'b1 |=> err_cnt_q >= $past(err_cnt_q),
		"error counter went backwards")
	`TWRC_ASSERT_ALWAYS(a_no_valid_in_reset, !arst_n |=> !out_valid_q,
		"result valid during reset")

endmodule

`default_nettype wire

[tb/twrc_checker.sv]
// checker for the tcp window rewrite checksum block: predicts each packet verdict and compares
`timescale 1ns / 1ps

module twrc_checker import twrc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data,

	input  wire logic                 in_valid,
	input  wire logic                 in_stall,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 last_byte,

	input  wire logic                 out_valid,
	input  wire logic                 out_stall,
	input  wire logic [1:0]           outcome,
	input  wire logic [15:0]          new_checksum,
	input  wire logic [CNT_W-1:0]     packet_count,
	input  wire logic [CNT_W-1:0]     modified_count,
	input  wire logic [CNT_W-1:0]     error_count,
	input  wire logic [CNT_W-1:0]     non_tcp_count,

	output int                        pending_results,
	output int                        mismatches
);

	typedef struct packed {
		outcome_t         kind;
		logic [15:0]      checksum;
		logic [CNT_W-1:0] packets;
		logic [CNT_W-1:0] modified;
		logic [CNT_W-1:0] errors;
		logic [CNT_W-1:0] non_tcp;
	} verdict_t;

	verdict_t verdicts_due [$];

	logic [15:0]      port_reg;
	logic [15:0]      window_reg;

	logic [15:0]      byte_pos;
	logic [IHL_W-1:0] hdr_len;
	logic [15:0]      tot_len;
	logic [7:0]       proto;
	logic [15:0]      sport;
	logic [7:0]       flags;
	logic [15:0]      run_sum;
	logic [7:0]       early [3];

	logic [CNT_W-1:0] cnt_packets;
	logic [CNT_W-1:0] cnt_modified;
	logic [CNT_W-1:0] cnt_errors;
	logic [CNT_W-1:0] cnt_non_tcp;

	initial mismatches = 0;

	function automatic logic [15:0] ones_add(input logic [15:0] s, input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, s} + {1'b0, x};
		return t[15:0] + {15'd0, t[16]};
	endfunction

	// even positions are the high byte of a big-endian word
	function automatic logic [15:0] place_byte(input logic odd, input logic [7:0] v);
		return 16'(v) << {~odd, 3'b000};
	endfunction

	function automatic logic [CNT_W-1:0] sat_step(input logic [CNT_W-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	task automatic report(input string msg);
		$display("%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic clear_packet();
		byte_pos = '0;
		hdr_len = '0;
		tot_len = '0;
		proto = '0;
		sport = '0;
		flags = '0;
		run_sum = '0;
		early = '{default: '0};
	endtask

	task automatic absorb_byte(input logic [7:0] b, input logic last);
		logic [15:0] p;
		logic [15:0] off;
		logic [15:0] tcp_len;
		logic [15:0] s;
		logic [7:0]  v;
		verdict_t    r;
		int          q;
		p = byte_pos;
		// bytes past the largest packet size are dropped and the position sticks
		if (p != MAX_PACKET_BYTES) begin
			if (p == POS_VER_IHL) hdr_len = {b[3:0], 2'b00};
			if (p < 3) early[p[1:0]] = b;
			if (p == POS_LEN_HI) tot_len = {b, 8'h00};
			if (p == POS_LEN_LO) tot_len = {tot_len[15:8], b};
			if (p == POS_PROTO) proto = b;
			if (p >= POS_ADDR_FIRST && p < POS_ADDR_END)
				run_sum = ones_add(run_sum, place_byte(p[0], b));
			if (p >= hdr_len) begin
				off = p - hdr_len;
				if (off == OFF_SPORT_HI) sport[15:8] = b;
				else if (off == OFF_SPORT_LO) sport[7:0] = b;
				else if (off == OFF_FLAGS) flags = b;
				if (p >= 4 && p < tot_len) begin
					v = b;
					if (off == OFF_WIN_HI) v = window_reg[15:8];
					else if (off == OFF_WIN_LO) v = window_reg[7:0];
					else if (off == OFF_CSUM_HI || off == OFF_CSUM_LO) v = 8'h00;
					run_sum = ones_add(run_sum, place_byte(p[0], v));
				end
			end
			// tcp bytes seen before the total length was known are summed now
			if (p == POS_LEN_LO) begin
				for (q = 0; q < 4; q++) begin
					v = (q < 3) ? early[q] : b;
					if (q >= hdr_len && q < tot_len)
						run_sum = ones_add(run_sum, place_byte(q[0], v));
				end
			end
			byte_pos = p + 1'b1;
		end
		if (last) begin
			r.checksum = '0;
			if (byte_pos < IP_MIN_BYTES) begin
				cnt_errors = sat_step(cnt_errors);
				r.kind = OUT_TOO_SHORT;
			end else begin
				cnt_packets = sat_step(cnt_packets);
				if (proto != PROTO_TCP) begin
					cnt_non_tcp = sat_step(cnt_non_tcp);
					r.kind = OUT_NOT_TCP;
				end else if (byte_pos < hdr_len + TCP_HDR_BYTES) begin
					cnt_errors = sat_step(cnt_errors);
					r.kind = OUT_TOO_SHORT;
				end else if (sport == port_reg && flags[ACK_BIT]) begin
					cnt_modified = sat_step(cnt_modified);
					r.kind = OUT_MODIFIED;
					tcp_len = (tot_len > hdr_len) ? tot_len - hdr_len : 16'd0;
					s = ones_add(run_sum, {8'h00, PROTO_TCP});
					s = ones_add(s, tcp_len);
					r.checksum = ~s;
				end else begin
					r.kind = OUT_PASSED;
				end
			end
			r.packets = cnt_packets;
			r.modified = cnt_modified;
			r.errors = cnt_errors;
			r.non_tcp = cnt_non_tcp;
			verdicts_due.push_back(r);
			clear_packet();
		end
	endtask

	task automatic compare_verdict();
		verdict_t w;
		if (verdicts_due.size() == 0) begin
			report($sformatf("result with no packet pending, outcome %0d", outcome));
			return;
		end
		w = verdicts_due.pop_front();
		if (outcome !== w.kind)
			report($sformatf("outcome %0d, expected %0d", outcome, w.kind));
		if (new_checksum !== w.checksum)
			report($sformatf("new_checksum %04h, expected %04h", new_checksum, w.checksum));
		if (packet_count !== w.packets)
			report($sformatf("packet_count %0d, expected %0d", packet_count, w.packets));
		if (modified_count !== w.modified)
			report($sformatf("modified_count %0d, expected %0d", modified_count, w.modified));
		if (error_count !== w.errors)
			report($sformatf("error_count %0d, expected %0d", error_count, w.errors));
		if (non_tcp_count !== w.non_tcp)
			report($sformatf("non_tcp_count %0d, expected %0d", non_tcp_count, w.non_tcp));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_reg = 16'd80;
			window_reg = 16'hFFFF;
			cnt_packets = '0;
			cnt_modified = '0;
			cnt_errors = '0;
			cnt_non_tcp = '0;
			clear_packet();
			verdicts_due.delete();
			pending_results <= 0;
		end else begin
			// results first, so a stray one is never matched against a packet ending now
			if (out_valid && !out_stall) compare_verdict();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LISTEN_PORT: begin
						port_reg = cfg_data;
					end
					REG_TARGET_WINDOW: begin
						window_reg = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (in_valid && !in_stall) absorb_byte(data_byte, last_byte);
			pending_results <= verdicts_due.size();
		end
	end

endmodule

[tb/testbench.sv]
// testbench top: packet stimulus, register writes and the final verdict
`timescale 1ns / 1ps

module testbench;
	import twrc_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int TIMEOUT_NS = 2_000_000;
	localparam int SEGMENT_BYTES = 240;

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           data_byte = '0;
	logic                 last_byte = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           outcome;
	logic [15:0]          new_checksum;
	logic [CNT_W-1:0]     packet_count;
	logic [CNT_W-1:0]     modified_count;
	logic [CNT_W-1:0]     error_count;
	logic [CNT_W-1:0]     non_tcp_count;

	int                   pending_results;
	int                   mismatches;
	int                   idle_pct = 21;
	int                   stall_pct = 56;
	int                   bytes_sent = 0;
	logic [15:0]          port_now = 16'd80;
	logic [7:0]           pkt [$];

	tcp_window_rewrite_checksum i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.outcome        (outcome),
		.new_checksum   (new_checksum),
		.packet_count   (packet_count),
		.modified_count (modified_count),
		.error_count    (error_count),
		.non_tcp_count  (non_tcp_count)
	);

	twrc_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.last_byte       (last_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.outcome         (outcome),
		.new_checksum    (new_checksum),
		.packet_count    (packet_count),
		.modified_count  (modified_count),
		.error_count     (error_count),
		.non_tcp_count   (non_tcp_count),
		.pending_results (pending_results),
		.mismatches      (mismatches)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Simulation FAILED");
		$finish;
	end

	// ip header at byte 0, tcp header at 4 * ihl; ip fields win where the two overlap
	task automatic make_packet(input int ihl, input logic [7:0] proto, input logic [15:0] sport,
			input logic [7:0] flags, input int payload, input int tl_delta, input fill_t fill,
			input int cut);
		int hdr;
		int n;
		int tl;
		int k;
		hdr = ihl * 4;
		n = hdr + TCP_HDR_BYTES + payload;
		if (n < IP_MIN_BYTES) n = IP_MIN_BYTES;
		pkt.delete();
		for (k = 0; k < n; k++) begin
			case (fill)
				FILL_ZERO: pkt.push_back(8'h00);
				FILL_ONES: pkt.push_back(8'hFF);
				default:   pkt.push_back(8'($urandom));
			endcase
		end
		pkt[hdr] = sport[15:8];
		pkt[hdr + 1] = sport[7:0];
		pkt[hdr + 13] = flags;
		tl = n + tl_delta;
		if (tl < 0) tl = 0;
		if (tl > 65535) tl = 65535;
		pkt[0] = {4'h4, 4'(ihl)};
		pkt[2] = 8'(tl >> 8);
		pkt[3] = 8'(tl);
		pkt[9] = proto;
		if (cut > 0) begin
			while (pkt.size() > cut) void'(pkt.pop_back());
		end
	endtask

	task automatic make_noise(input int n);
		pkt.delete();
		repeat (n) pkt.push_back(8'($urandom));
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	task automatic send_packet();
		int k;
		for (k = 0; k < pkt.size(); k++) send_byte(pkt[k], k == pkt.size() - 1);
	endtask

	// hold the sender until every packet verdict is back and the pipeline is quiet
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] port, input logic [15:0] window);
		cfg_valid <= 1'b1;
		cfg_index <= REG_LISTEN_PORT;
		cfg_data <= port;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_TARGET_WINDOW;
		cfg_data <= window;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		port_now = port;
	endtask

	// mostly well-formed tcp with random content, the rest malformed or noise
	task automatic random_packet();
		int          kind;
		int          ihl;
		int          pay;
		logic [15:0] sp;
		logic [7:0]  fl;
		kind = $urandom_range(99);
		ihl = ($urandom_range(9) < 7) ? 5 : $urandom_range(15, 6);
		pay = $urandom_range(24);
		sp = ($urandom_range(9) < 6) ? port_now : 16'($urandom);
		fl = 8'($urandom);
		fl[ACK_BIT] = ($urandom_range(9) < 7);
		if (kind < 55)
			make_packet(ihl, PROTO_TCP, sp, fl, pay, 0, FILL_RANDOM, 0);
		else if (kind < 65)
			make_packet(ihl, PROTO_TCP, sp, fl, pay, int'($urandom_range(60)) - 30,
				FILL_RANDOM, 0);
		else if (kind < 73)
			make_packet($urandom_range(4), PROTO_TCP, sp, fl, pay, 0, FILL_RANDOM, 0);
		else if (kind < 81)
			make_packet(ihl, 8'($urandom), sp, fl, pay, 0, FILL_RANDOM, 0);
		else if (kind < 88)
			make_packet(ihl, PROTO_TCP, sp, fl, pay, 0, FILL_RANDOM, $urandom_range(19, 1));
		else if (kind < 93)
			make_packet(ihl, PROTO_TCP, sp, fl, pay, 0, FILL_RANDOM,
				$urandom_range(ihl * 4 + 19, 20));
		else
			make_noise($urandom_range(60, 1));
	endtask

	task automatic run_segment(input logic [15:0] port, input logic [15:0] window);
		int goal;
		drain();
		set_config(port, window);
		goal = bytes_sent + SEGMENT_BYTES;
		while (bytes_sent < goal) begin
			random_packet();
			send_packet();
			if ($urandom_range(19) == 0) drain();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed packets under the reset register values
		pkt = '{8'hFF};
		send_packet();
		make_packet(5, PROTO_TCP, 16'd80, 8'h10, 1, 0, FILL_ONES, 0);
		send_packet();
		make_packet(5, PROTO_TCP, 16'd80, 8'hFF, 0, 0, FILL_ZERO, 0);
		send_packet();
		make_packet(5, PROTO_TCP, 16'd80, 8'hEF, 2, 0, FILL_ONES, 0);
		send_packet();
		make_packet(5, PROTO_TCP, 16'd81, 8'h10, 0, 0, FILL_RANDOM, 0);
		send_packet();
		make_packet(5, 8'd17, 16'd80, 8'h10, 0, 0, FILL_RANDOM, IP_MIN_BYTES);
		send_packet();
		make_packet(5, PROTO_TCP, 16'd80, 8'h10, 0, 0, FILL_ONES, IP_MIN_BYTES - 1);
		send_packet();
		make_packet(5, PROTO_TCP, 16'd80, 8'h10, 0, 0, FILL_RANDOM, 39);
		send_packet();
		make_packet(0, PROTO_TCP, 16'd80, 8'h10, 4, 0, FILL_RANDOM, 0);
		send_packet();
		make_packet(3, PROTO_TCP, 16'd80, 8'h10, 1, 0, FILL_RANDOM, 0);
		send_packet();
		make_packet(15, PROTO_TCP, 16'd80, 8'h10, 3, 0, FILL_RANDOM, 0);
		send_packet();
		make_packet(5, PROTO_TCP, 16'd80, 8'h10, 5, 12, FILL_RANDOM, 0);
		send_packet();
		make_packet(5, PROTO_TCP, 16'd80, 8'h10, 5, -30, FILL_RANDOM, 0);
		send_packet();

		idle_pct = 21;
		stall_pct = 56;
		run_segment(16'h0000, 16'h0000);
		run_segment(16'hFFFF, 16'hFFFF);

		idle_pct = 56;
		stall_pct = 21;
		run_segment(16'd443, 16'($urandom));
		run_segment(16'($urandom), 16'h8000);

		idle_pct = 0;
		stall_pct = 0;
		run_segment(16'hFFFF, 16'h0000);
		run_segment(16'($urandom), 16'($urandom));

		drain();
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
